FILE: sv/kep_pkg.sv
// Shared constants for the keystroke entropy pool: default sizes,
// operation and source codes, and the stirring generator's coefficients.
// No dependencies.
package kep_pkg;

  // Default sizes, handed to the top level's parameters
  localparam int FRESH_DEPTH_DEF   = 256;
  localparam int RECYCLE_DEPTH_DEF = 256;
  localparam int CAPTURE_BITS_DEF  = 4;

  // Item field widths
  localparam int MODE_W   = 3;
  localparam int KEY_W    = 8;
  localparam int BITS_W   = 15;
  localparam int VALUE_W  = 9;
  localparam int SOURCE_W = 2;
  localparam int LOADED_W = 12;
  localparam int COUNT_W  = 9;

  // Operation codes carried in the request's mode field
  localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KEY   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TAKE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd4;

  // Source codes of a returned byte
  localparam logic [SOURCE_W-1:0] SRC_NONE     = 2'd0;
  localparam logic [SOURCE_W-1:0] SRC_RECYCLED = 2'd1;
  localparam logic [SOURCE_W-1:0] SRC_FRESH    = 2'd2;
  localparam logic [SOURCE_W-1:0] SRC_PSEUDO   = 2'd3;

  // 16-bit linear congruential generator
  localparam logic [15:0] LCG_MUL = 16'd31421;
  localparam logic [15:0] LCG_ADD = 16'd6927;

endpackage

FILE: sv/kep_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Used for both byte pools. No dependencies.
module kep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/keystroke_entropy_pool_top.sv
// Keystroke entropy pool: sequencer, key timing capture, load, stir and take.
// Depends on kep_pkg and two kep_ram instances (fresh stack, recycle pool).
//
// Usage:
//   Input channel (in_*): one request per handshake. in_tuser carries the
//   operation (tick, key event, load recycle pool, take byte, flush pool);
//   in_tdata carries key code, typeahead flag and requested load bit count.
//   Output channel (out_*): exactly one result per request, in order.
//   out_tuser gives the byte's source, out_tdata the byte (signed, negative
//   for the generator fallback), bits loaded and both pool levels.
//   A take that wraps the cursor stirs the whole pool before it reads.
//   The stir and load walks go one pool entry a cycle through the single
//   read and write port of each pool RAM, and during a stir the one 16x16
//   generator multiplier steps once a cycle. One request is in flight at a
//   time; in_tready is high only while the sequencer is idle, so the next
//   request is taken only after the last result has been produced.
//   A finished result sits in the output register; the block takes the
//   next request while it waits and stalls only when a second result would
//   have to overwrite it. Synchronous active-low reset empties both pools
//   and clears the counter, key history and generator state.
module keystroke_entropy_pool_top
  import kep_pkg::*;
#(
  parameter int FRESH_DEPTH   = FRESH_DEPTH_DEF,
  parameter int RECYCLE_DEPTH = RECYCLE_DEPTH_DEF,
  parameter int CAPTURE_BITS  = CAPTURE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // key_code[7:0], more_pending[8], load_bits[23:9]
  input  logic [2:0]  in_tuser,   // mode[2:0]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // value[8:0], bits_loaded[20:9], fresh_count[29:21],
                                  // recycled_count[38:30], zero[39]
  output logic [1:0]  out_tuser   // source[1:0]
);

  localparam int FA_W   = $clog2(FRESH_DEPTH);
  localparam int FL_W   = $clog2(FRESH_DEPTH + 1);
  localparam int RA_W   = $clog2(RECYCLE_DEPTH);
  localparam int RL_W   = $clog2(RECYCLE_DEPTH + 1);
  localparam int CMP_W  = 16;
  localparam logic [7:0] CAP_MASK = 8'((1 << CAPTURE_BITS) - 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_STIR   = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // Control state
  logic [2:0]          state_r, state_nxt;
  logic [FL_W-1:0]     fresh_lvl_r, fresh_lvl_nxt;
  logic [RL_W-1:0]     rec_lvl_r, rec_lvl_nxt;
  logic [RA_W-1:0]     cursor_r, cursor_nxt;
  logic [15:0]         lcg_r, lcg_nxt;
  logic [7:0]          tick_r, tick_nxt;
  logic [7:0]          held_r, held_nxt;
  logic [3:0]          phase_r, phase_nxt;
  logic [8:0]          last_key_r, last_key_nxt;
  logic [8:0]          prior_key_r, prior_key_nxt;
  logic [RL_W-1:0]     rem_r, rem_nxt;
  logic                pend_r, pend_nxt;
  logic [RA_W-1:0]     st_addr_r, st_addr_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;

  // Payload registers
  logic [MODE_W-1:0]   mode_r;
  logic [KEY_W-1:0]    key_r;
  logic                more_r;
  logic [BITS_W-1:0]   bits_r;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic [SOURCE_W-1:0] src_r, src_nxt;
  logic [39:0]         out_tdata_r, out_tdata_nxt;
  logic [1:0]          out_tuser_r, out_tuser_nxt;

  // Pool RAM ports
  logic            fr_we;
  logic [FA_W-1:0] fr_waddr, fr_raddr;
  logic [7:0]      fr_wdata, fr_rdata;
  logic            rc_we;
  logic [RA_W-1:0] rc_waddr, rc_raddr;
  logic [7:0]      rc_wdata, rc_rdata;

  // Shared generator step
  logic [31:0] lcg_prod;
  logic [15:0] lcg_step;

  // Capture datapath
  logic [8:0]  key_bits;
  logic [7:0]  cap;
  logic [15:0] packed_bits, shifted_bits;
  logic [3:0]  phase_sum, phase_left;
  logic [15:0] keep_mask;

  // Load sizing
  logic [CMP_W-1:0] load_req, load_n;

  // Cursor advance
  logic [RL_W-1:0] cursor_inc;

  logic in_fire;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign lcg_prod = lcg_r * LCG_MUL;
  assign lcg_step = lcg_prod[15:0] + LCG_ADD;

  // Pack the captured bits; at most one byte completes per capture.
  // The counter has already advanced for this key event when it is sampled.
  assign key_bits     = {1'b1, key_r};
  assign cap          = (tick_r + 8'd1) & CAP_MASK;
  assign packed_bits  = (16'(held_r) << CAPTURE_BITS) | 16'(cap);
  assign phase_sum    = phase_r + 4'(CAPTURE_BITS);
  assign shifted_bits = (phase_sum >= 4'd8) ? (packed_bits >> 8) : packed_bits;
  assign phase_left   = (phase_sum >= 4'd8) ? (phase_sum - 4'd8) : phase_sum;
  assign keep_mask    = (16'd1 << phase_left) - 16'd1;

  // Bytes a load moves: ceil(bits / 8), bounded by supply and pool size
  always_comb begin
    load_req = (CMP_W'(bits_r) + CMP_W'(7)) >> 3;
    load_n   = load_req;
    if (load_n > CMP_W'(fresh_lvl_r)) begin
      load_n = CMP_W'(fresh_lvl_r);
    end
    if (load_n > CMP_W'(RECYCLE_DEPTH)) begin
      load_n = CMP_W'(RECYCLE_DEPTH);
    end
  end

  assign cursor_inc = RL_W'(cursor_r) + RL_W'(1);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    fresh_lvl_nxt  = fresh_lvl_r;
    rec_lvl_nxt    = rec_lvl_r;
    cursor_nxt     = cursor_r;
    lcg_nxt        = lcg_r;
    tick_nxt       = tick_r;
    held_nxt       = held_r;
    phase_nxt      = phase_r;
    last_key_nxt   = last_key_r;
    prior_key_nxt  = prior_key_r;
    rem_nxt        = rem_r;
    pend_nxt       = pend_r;
    st_addr_nxt    = st_addr_r;
    value_nxt      = value_r;
    src_nxt        = src_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    fr_we          = 1'b0;
    fr_waddr       = FA_W'(fresh_lvl_r);
    fr_wdata       = packed_bits[7:0];
    fr_raddr       = FA_W'(fresh_lvl_r - FL_W'(1));
    rc_we          = 1'b0;
    rc_waddr       = RA_W'(rec_lvl_r);
    rc_wdata       = fr_rdata;
    rc_raddr       = cursor_r;

    // Drop the result once the receiver takes it
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        value_nxt = '0;
        src_nxt   = SRC_NONE;
        state_nxt = ST_DONE;
        case (mode_r)
          MODE_TICK: begin
            tick_nxt = tick_r + 8'd1;
          end
          MODE_KEY: begin
            tick_nxt = tick_r + 8'd1;
            if (!more_r) begin
              if (key_bits != last_key_r || key_bits != prior_key_r) begin
                // Capture timing bits, push a completed byte, clear the counter
                tick_nxt  = '0;
                held_nxt  = 8'(shifted_bits & keep_mask);
                phase_nxt = phase_left;
                if (phase_sum >= 4'd8 && fresh_lvl_r < FL_W'(FRESH_DEPTH)) begin
                  fr_we         = 1'b1;
                  fresh_lvl_nxt = fresh_lvl_r + FL_W'(1);
                end
              end
              prior_key_nxt = last_key_r;
              last_key_nxt  = key_bits;
            end
          end
          MODE_LOAD: begin
            rec_lvl_nxt = '0;
            cursor_nxt  = '0;
            rem_nxt     = RL_W'(load_n);
            pend_nxt    = 1'b0;
            state_nxt   = ST_LOAD;
          end
          MODE_TAKE: begin
            if (rec_lvl_r != '0) begin
              src_nxt = SRC_RECYCLED;
              if (cursor_inc >= rec_lvl_r) begin
                cursor_nxt = '0;
                rem_nxt    = rec_lvl_r;
                pend_nxt   = 1'b0;
                state_nxt  = ST_STIR;
              end else begin
                cursor_nxt = RA_W'(cursor_inc);
                rc_raddr   = RA_W'(cursor_inc);
                state_nxt  = ST_RDWAIT;
              end
            end else if (fresh_lvl_r != '0) begin
              // Pop: read the top entry
              src_nxt       = SRC_FRESH;
              fresh_lvl_nxt = fresh_lvl_r - FL_W'(1);
              state_nxt     = ST_RDWAIT;
            end else begin
              lcg_nxt   = lcg_step;
              value_nxt = {1'b1, ~lcg_step[7:0]};
              src_nxt   = SRC_PSEUDO;
            end
          end
          MODE_FLUSH: begin
            rec_lvl_nxt = '0;
            cursor_nxt  = '0;
          end
          default: begin
          end
        endcase
      end

      ST_LOAD: begin
        // Read the fresh top, write last cycle's byte into the pool
        pend_nxt = 1'b0;
        if (rem_r != '0) begin
          fresh_lvl_nxt = fresh_lvl_r - FL_W'(1);
          rem_nxt       = rem_r - RL_W'(1);
          pend_nxt      = 1'b1;
        end
        if (pend_r) begin
          rc_we       = 1'b1;
          rec_lvl_nxt = rec_lvl_r + RL_W'(1);
        end
        if (rem_r == '0 && !pend_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_STIR: begin
        // Walk the pool from the top down, xor each entry with a generator byte
        pend_nxt = 1'b0;
        if (rem_r != '0) begin
          rc_raddr    = RA_W'(rem_r - RL_W'(1));
          st_addr_nxt = RA_W'(rem_r - RL_W'(1));
          rem_nxt     = rem_r - RL_W'(1);
          pend_nxt    = 1'b1;
        end
        if (pend_r) begin
          lcg_nxt  = lcg_step;
          rc_we    = 1'b1;
          rc_waddr = st_addr_r;
          rc_wdata = rc_rdata ^ lcg_step[7:0];
        end
        if (rem_r == '0 && !pend_r) begin
          // Pool settled: read the entry at the wrapped cursor
          rc_raddr  = cursor_r;
          state_nxt = ST_RDWAIT;
        end
      end

      ST_RDWAIT: begin
        value_nxt = (src_r == SRC_RECYCLED) ? {1'b0, rc_rdata} : {1'b0, fr_rdata};
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = src_r;
          out_tdata_nxt  = {1'b0,
                            COUNT_W'(rec_lvl_r),
                            COUNT_W'(fresh_lvl_r),
                            (mode_r == MODE_LOAD) ? LOADED_W'({rec_lvl_r, 3'b000})
                                                  : LOADED_W'(0),
                            value_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fresh_lvl_r  <= '0;
      rec_lvl_r    <= '0;
      cursor_r     <= '0;
      lcg_r        <= '0;
      tick_r       <= '0;
      held_r       <= '0;
      phase_r      <= '0;
      last_key_r   <= '0;
      prior_key_r  <= '0;
      rem_r        <= '0;
      pend_r       <= 1'b0;
      st_addr_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fresh_lvl_r  <= fresh_lvl_nxt;
      rec_lvl_r    <= rec_lvl_nxt;
      cursor_r     <= cursor_nxt;
      lcg_r        <= lcg_nxt;
      tick_r       <= tick_nxt;
      held_r       <= held_nxt;
      phase_r      <= phase_nxt;
      last_key_r   <= last_key_nxt;
      prior_key_r  <= prior_key_nxt;
      rem_r        <= rem_nxt;
      pend_r       <= pend_nxt;
      st_addr_r    <= st_addr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_tuser;
      key_r  <= in_tdata[7:0];
      more_r <= in_tdata[8];
      bits_r <= in_tdata[23:9];
    end
    value_r     <= value_nxt;
    src_r       <= src_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // Fresh stack storage
  kep_ram #(
    .WIDTH (8),
    .DEPTH (FRESH_DEPTH)
  ) u_fresh_ram (
    .clk   (clk),
    .we    (fr_we),
    .waddr (fr_waddr),
    .wdata (fr_wdata),
    .raddr (fr_raddr),
    .rdata (fr_rdata)
  );

  // Recycle pool storage
  kep_ram #(
    .WIDTH (8),
    .DEPTH (RECYCLE_DEPTH)
  ) u_recycle_ram (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .raddr (rc_raddr),
    .rdata (rc_rdata)
  );

endmodule

FILE: verif/keystroke_entropy_pool_top_tb.sv
// Self-checking bench for keystroke_entropy_pool_top: directed and random requests
// against an in-bench predictor of the pools, key capture and stirring generator.
// Depends on kep_pkg and the keystroke_entropy_pool_top RTL.
`timescale 1ns / 100ps

module keystroke_entropy_pool_top_tb;
  import kep_pkg::*;

  localparam int FRESH_SLOTS   = FRESH_DEPTH_DEF;
  localparam int RECYCLE_SLOTS = RECYCLE_DEPTH_DEF;
  localparam int CAP_BITS      = CAPTURE_BITS_DEF;

  // Mode codes the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

  localparam logic [BITS_W-1:0] LOAD_BITS_MAX = 15'h7FFF;
  localparam int HOLD_CYCLES  = 700;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [SOURCE_W-1:0] source;
    logic [LOADED_W-1:0] loaded;
    logic [COUNT_W-1:0]  fresh;
    logic [COUNT_W-1:0]  recycled;
  } pool_result_t;

  // Tracks pool state per accepted request and checks each returned result
  class pool_scoreboard;
    logic [7:0]   fresh_stack [FRESH_SLOTS];
    int unsigned  fresh_level;
    logic [7:0]   recycle_pool [RECYCLE_SLOTS];
    int unsigned  recycle_level;
    int unsigned  recycle_cursor;
    logic [15:0]  lcg;
    logic [7:0]   tick_count;
    int unsigned  held_bits;
    int unsigned  held_count;
    logic [8:0]   last_key;
    logic [8:0]   prior_key;
    pool_result_t pending_results [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  source_hits [4];
    int unsigned  stirs, dropped, repeats_skipped, typeahead_skipped, loads, peak_fresh;

    function new();
      foreach (fresh_stack[i]) fresh_stack[i] = '0;
      fresh_level = 0;
      clear_pool();
      lcg = '0;
      tick_count = '0;
      held_bits = 0;
      held_count = 0;
      last_key = '0;
      prior_key = '0;
      mismatches = 0;
      checked = 0;
      foreach (source_hits[i]) source_hits[i] = 0;
      stirs = 0;
      dropped = 0;
      repeats_skipped = 0;
      typeahead_skipped = 0;
      loads = 0;
      peak_fresh = 0;
    endfunction

    function logic [15:0] lcg_step();
      lcg = lcg * LCG_MUL + LCG_ADD;
      return lcg;
    endfunction

    function void clear_pool();
      foreach (recycle_pool[i]) recycle_pool[i] = '0;
      recycle_level = 0;
      recycle_cursor = 0;
    endfunction

    // Walk the pool from the top entry down, folding in one generator byte each
    function void stir_pool();
      int i;
      logic [15:0] step;
      stirs++;
      for (i = recycle_level; i > 0; i--) begin
        step = lcg_step();
        recycle_pool[i-1] ^= step[7:0];
      end
    endfunction

    // Append the counter's low bits; push every whole byte, drop it when full
    function void capture_timing();
      held_bits = (held_bits << CAP_BITS) | (tick_count & ((1 << CAP_BITS) - 1));
      held_count += CAP_BITS;
      while (held_count >= 8) begin
        if (fresh_level < FRESH_SLOTS) begin
          fresh_stack[fresh_level] = held_bits[7:0];
          fresh_level++;
        end else begin
          dropped++;
        end
        held_count -= 8;
        held_bits >>= 8;
      end
      held_bits &= (1 << held_count) - 1;
      tick_count = '0;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic more, logic [BITS_W-1:0] bits);
      pool_result_t r;
      int unsigned n;
      logic [8:0] kb;
      logic [15:0] step;
      r = '0;
      case (mode)
        MODE_TICK: tick_count++;
        MODE_KEY: begin
          tick_count++;
          if (more) begin
            typeahead_skipped++;
          end else begin
            kb = {1'b1, key};
            if (kb != last_key || kb != prior_key) capture_timing();
            else repeats_skipped++;
            prior_key = last_key;
            last_key = kb;
          end
        end
        MODE_LOAD: begin
          loads++;
          n = (int'(bits) + 7) / 8;
          if (n > fresh_level) n = fresh_level;
          if (n > RECYCLE_SLOTS) n = RECYCLE_SLOTS;
          clear_pool();
          repeat (n) begin
            fresh_level--;
            recycle_pool[recycle_level] = fresh_stack[fresh_level];
            recycle_level++;
          end
          r.loaded = LOADED_W'(recycle_level * 8);
        end
        MODE_TAKE: begin
          if (recycle_level > 0) begin
            recycle_cursor++;
            if (recycle_cursor >= recycle_level) begin
              recycle_cursor = 0;
              stir_pool();
            end
            r.value = {1'b0, recycle_pool[recycle_cursor]};
            r.source = SRC_RECYCLED;
          end else if (fresh_level > 0) begin
            fresh_level--;
            r.value = {1'b0, fresh_stack[fresh_level]};
            r.source = SRC_FRESH;
          end else begin
            step = lcg_step();
            r.value = {1'b0, step[7:0]} ^ 9'h1FF;
            r.source = SRC_PSEUDO;
          end
          source_hits[r.source]++;
        end
        MODE_FLUSH: clear_pool();
        default: ;
      endcase
      if (fresh_level > peak_fresh) peak_fresh = fresh_level;
      r.fresh = COUNT_W'(fresh_level);
      r.recycled = COUNT_W'(recycle_level);
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [39:0] data, logic [SOURCE_W-1:0] user);
      pool_result_t want, got;
      got.value = data[8:0];
      got.source = user;
      got.loaded = data[20:9];
      got.fresh = data[29:21];
      got.recycled = data[38:30];
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result with no request outstanding: value=%0d source=%0d",
                   $realtime, $signed(got.value), got.source);
        return;
      end
      want = pending_results.pop_front();
      if (got.value !== want.value || got.source !== want.source ||
          got.loaded !== want.loaded || got.fresh !== want.fresh ||
          got.recycled !== want.recycled || data[39] !== 1'b0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("[%0t] result %0d mismatch", $realtime, checked);
          $display("  expected value=%0d source=%0d loaded=%0d fresh=%0d recycled=%0d pad=0",
                   $signed(want.value), want.source, want.loaded, want.fresh, want.recycled);
          $display("  actual   value=%0d source=%0d loaded=%0d fresh=%0d recycled=%0d pad=%b",
                   $signed(got.value), got.source, got.loaded, got.fresh, got.recycled,
                   data[39]);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // key_code[7:0], more_pending[8], load_bits[23:9]
  logic [2:0]  in_tuser;   // mode[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // value[8:0], bits_loaded[20:9], fresh_count[29:21],
                           // recycled_count[38:30], zero[39]
  logic [1:0]  out_tuser;  // source[1:0]

  pool_scoreboard sb = new();
  int unsigned    idle_pct;
  int unsigned    requests_sent;
  logic [7:0]     prev_key;
  bit             hold_done;

  keystroke_entropy_pool_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Log both handshakes at the rising edge; results first, then the new request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready)
        sb.note_request(in_tuser, in_tdata[7:0], in_tdata[8], in_tdata[23:9]);
    end
  end

  // Drive result-side backpressure; hold off once for a long stretch to fill the block
  initial begin
    out_tready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !hold_done && sb.checked >= 300) begin
        hold_done = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Offer one request and wait for it to be taken; idle afterwards at random
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                              input logic more, input logic [BITS_W-1:0] bits);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = mode;
    in_tdata = {bits, more, key};
    do @(posedge clk); while (!in_tready);
    if (mode <= MODE_FLUSH) requests_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(int unsigned same_pct);
    if ($urandom_range(0, 99) >= same_pct) prev_key = KEY_W'($urandom_range(0, 255));
    return prev_key;
  endfunction

  function automatic logic [BITS_W-1:0] pick_load_bits();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return BITS_W'($urandom_range(0, 80));
    if (sel < 8) return BITS_W'($urandom_range(81, 2100));
    return BITS_W'($urandom_range(0, 32767));
  endfunction

  // Key-heavy request to build up the fresh stack past full
  task automatic send_fill_item();
    if ($urandom_range(0, 99) < 6)
      send_request(MODE_TICK, KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   BITS_W'($urandom_range(0, 32767)));
    else
      send_request(MODE_KEY, pick_key(20), $urandom_range(0, 99) < 8,
                   BITS_W'($urandom_range(0, 32767)));
  endtask

  // Mixed traffic across every operation
  task automatic send_mixed_item();
    int unsigned pick;
    logic [BITS_W-1:0] noise;
    pick = $urandom_range(0, 99);
    noise = BITS_W'($urandom_range(0, 32767));
    if (pick < 30)
      send_request(MODE_KEY, pick_key(25), $urandom_range(0, 99) < 15, noise);
    else if (pick < 40)
      send_request(MODE_TICK, KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   noise);
    else if (pick < 68)
      send_request(MODE_TAKE, KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   noise);
    else if (pick < 82)
      send_request(MODE_LOAD, KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   pick_load_bits());
    else if (pick < 88)
      send_request(MODE_FLUSH, KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   noise);
    else if (pick < 91)
      send_request(MODE_W'($urandom_range(MODE_SPARE_A, MODE_SPARE_C)),
                   KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), noise);
    else
      send_request(MODE_KEY, pick_key(0), 1'b0, noise);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_TICK;
    idle_pct = 25;
    requests_sent = 0;
    prev_key = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fallback bytes from empty pools, then counter ticks
    send_request(MODE_TAKE, 8'h00, 1'b0, '0);
    send_request(MODE_TAKE, 8'hFF, 1'b1, LOAD_BITS_MAX);
    send_request(MODE_TICK, 8'h00, 1'b0, '0);
    send_request(MODE_TICK, 8'hFF, 1'b1, LOAD_BITS_MAX);
    // Same key three times: the second repeat captures nothing
    send_request(MODE_KEY, 8'h00, 1'b0, '0);
    send_request(MODE_KEY, 8'h00, 1'b0, '0);
    send_request(MODE_KEY, 8'h00, 1'b0, '0);
    // Typeahead pending suppresses capture, then normal captures
    send_request(MODE_KEY, 8'hFF, 1'b1, LOAD_BITS_MAX);
    send_request(MODE_KEY, 8'hFF, 1'b0, '0);
    send_request(MODE_KEY, 8'h5A, 1'b0, '0);
    send_request(MODE_KEY, 8'hA5, 1'b0, LOAD_BITS_MAX);
    send_request(MODE_KEY, 8'h3C, 1'b0, '0);
    // Empty load, short load, take through a cursor wrap, flush
    send_request(MODE_LOAD, 8'h00, 1'b0, '0);
    send_request(MODE_LOAD, 8'h00, 1'b0, 15'd9);
    send_request(MODE_TAKE, 8'h00, 1'b0, '0);
    send_request(MODE_TAKE, 8'h00, 1'b0, '0);
    send_request(MODE_FLUSH, 8'hFF, 1'b1, LOAD_BITS_MAX);
    // Pop the fresh stack, fall back, then a load far beyond supply
    send_request(MODE_TAKE, 8'h00, 1'b0, '0);
    send_request(MODE_TAKE, 8'h00, 1'b0, '0);
    send_request(MODE_LOAD, 8'h00, 1'b0, LOAD_BITS_MAX);
    // Ignored modes
    send_request(MODE_SPARE_A, 8'hFF, 1'b1, LOAD_BITS_MAX);
    send_request(MODE_SPARE_A + 3'd1, 8'h00, 1'b0, '0);
    send_request(MODE_SPARE_C, 8'hFF, 1'b1, LOAD_BITS_MAX);

    // Fill the fresh stack past full, then move the whole stack over
    idle_pct = 20;
    repeat (760) send_fill_item();
    send_request(MODE_LOAD, 8'h00, 1'b0, LOAD_BITS_MAX);

    // Mixed traffic with changing idle density, quiet at the end
    while (requests_sent < 1325) begin
      if (requests_sent % 100 == 0)
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      send_mixed_item();
    end
    idle_pct = 0;
    while (requests_sent < 1525) send_mixed_item();
    @(negedge clk);
    in_tvalid = 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d recycled, %0d fresh, %0d fallback bytes,",
             requests_sent, sb.source_hits[SRC_RECYCLED], sb.source_hits[SRC_FRESH],
             sb.source_hits[SRC_PSEUDO]);
    $display("%0d stirs, %0d loads; fresh stack peaked at %0d, %0d bytes dropped.",
             sb.stirs, sb.loads, sb.peak_fresh, sb.dropped);
    $display("Skipped %0d repeated keys and %0d typeahead keys.",
             sb.repeats_skipped, sb.typeahead_skipped);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatched or stray results", sb.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/kep_pkg.sv
sv/kep_ram.sv
sv/keystroke_entropy_pool_top.sv
verif/keystroke_entropy_pool_top_tb.sv
